FILE: hdl/kti_pkg.sv
package kti_pkg;

    localparam int MAX_POINTS = 16;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int VALUE_W = 32;
    localparam int DUR_W   = 20;
    localparam int TIME_W  = 24;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    // (to - from) needs one extra bit; product of that with elapsed as a signed value
    localparam int DIFF_W = VALUE_W + 1;
    localparam int PROD_W = DIFF_W + DUR_W + 1;
    // |product| < 2^VALUE_W * duration, so the magnitude fits here
    localparam int MAG_W  = VALUE_W + DUR_W;
    localparam int STEP_W = $clog2(VALUE_W + 1);

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_START  = 2'd1,
        OP_RENDER = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_START_RD,
        ST_START_ACC,
        ST_SEARCH_RD,
        ST_SEARCH_CHK,
        ST_FETCH_TO,
        ST_FETCH_FROM,
        ST_DIFF,
        ST_PROD,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        opcode_t             opcode;
        logic [DUR_W-1:0]    segment_duration;
        logic [VALUE_W-1:0]  point_target;
        logic [TIME_W-1:0]   query_time;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  tween_value;
        logic [TIME_W-1:0]   clamped_time;
        logic                accepted;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: hdl/kti_ram.sv
module kti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/kti_div.sv
module kti_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [kti_pkg::MAG_W-1:0]           dividend,
    input  logic [kti_pkg::DUR_W-1:0]           divisor,
    output logic [kti_pkg::VALUE_W-1:0]         quotient,
    output kti_pkg::div_status_t                status
);

    logic                               busy_reg, busy_next;
    logic                               done_reg, done_next;
    logic [kti_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [kti_pkg::DUR_W-1:0]          rem_reg, rem_next;
    logic [kti_pkg::VALUE_W-1:0]        quo_reg, quo_next;
    logic [kti_pkg::DUR_W-1:0]          dsr_reg, dsr_next;
    logic [kti_pkg::DUR_W:0]            shifted;
    logic [kti_pkg::DUR_W:0]            trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        shifted   = {rem_reg, quo_reg[kti_pkg::VALUE_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (start)
        begin
            // upper part of the dividend is already below the divisor
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend[kti_pkg::MAG_W-1:kti_pkg::VALUE_W];
            quo_next  = dividend[kti_pkg::VALUE_W-1:0];
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = trial[kti_pkg::DUR_W-1:0];
                quo_next = {quo_reg[kti_pkg::VALUE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[kti_pkg::DUR_W-1:0];
                quo_next = {quo_reg[kti_pkg::VALUE_W-2:0], 1'b0};
            end
            step_next = step_reg + kti_pkg::STEP_W'(1);
            if (step_reg == kti_pkg::STEP_W'(kti_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: hdl/keyframe_tween_interpolator.sv
// Append, no-op, and start or render over an empty table go from dispatch straight to output;
// start walks all N points to build the end-time table, and render searches k points and
// then divides, skipping the divider when the found segment has zero length.
// One item at a time: a new input is taken only in idle, once the last result is registered.
// Render time is set by the point search and the 32-step serial divider.
// Reset: rst_n clears point count, total time, last value, start value; tables keep contents.
module keyframe_tween_interpolator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  kti_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output kti_pkg::out_item_t             out_data,
    input  logic                           cfg_wr_en,
    input  logic [kti_pkg::VALUE_W-1:0]    cfg_wr_data
);

    kti_pkg::state_t                       state_reg, state_next;
    kti_pkg::in_item_t                     cmd_reg, cmd_next;
    logic [kti_pkg::CNT_W-1:0]             count_reg, count_next;
    logic [kti_pkg::TIME_W-1:0]            total_reg, total_next;
    logic [kti_pkg::VALUE_W-1:0]           last_reg, last_next;
    logic [kti_pkg::VALUE_W-1:0]           start_val_reg;
    logic                                  out_valid_reg, out_valid_next;
    kti_pkg::out_item_t                    out_data_reg, out_data_next;

    logic [kti_pkg::IDX_W-1:0]             idx_reg, idx_next;
    logic [kti_pkg::TIME_W-1:0]            run_reg, run_next;
    logic [kti_pkg::TIME_W-1:0]            t_reg, t_next;
    logic [kti_pkg::TIME_W-1:0]            prev_end_reg, prev_end_next;
    logic                                  acc_reg, acc_next;
    logic [kti_pkg::VALUE_W-1:0]           to_reg, to_next;
    logic [kti_pkg::VALUE_W-1:0]           from_reg, from_next;
    logic [kti_pkg::DUR_W-1:0]             d_reg, d_next;
    logic [kti_pkg::DUR_W-1:0]             elapsed_reg, elapsed_next;
    logic signed [kti_pkg::DIFF_W-1:0]     diff_reg, diff_next;
    logic signed [kti_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                                  neg_reg, neg_next;

    logic [kti_pkg::CNT_W-1:0]             count_m1;
    logic [kti_pkg::IDX_W-1:0]             last_idx;
    logic [kti_pkg::TIME_W:0]              run_sum;
    logic [kti_pkg::TIME_W-1:0]            run_sat;
    logic [kti_pkg::TIME_W-1:0]            elapsed_full;
    logic [kti_pkg::VALUE_W-1:0]           from_sel;
    logic signed [kti_pkg::PROD_W-1:0]     prod_abs;
    logic [kti_pkg::DIFF_W-1:0]            q_signed;
    logic [kti_pkg::DIFF_W-1:0]            tween_sum;

    logic                                  val_we, dur_we, end_we;
    logic [kti_pkg::IDX_W-1:0]             val_raddr;
    logic [kti_pkg::VALUE_W-1:0]           val_rdata;
    logic [kti_pkg::DUR_W-1:0]             dur_rdata;
    logic [kti_pkg::TIME_W-1:0]            end_rdata;

    logic                                  div_start;
    logic [kti_pkg::VALUE_W-1:0]           div_quo;
    kti_pkg::div_status_t                  div_status;

    kti_ram #(.WIDTH(kti_pkg::VALUE_W), .DEPTH(kti_pkg::MAX_POINTS)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (count_reg[kti_pkg::IDX_W-1:0]),
        .wdata (cmd_reg.point_target),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    kti_ram #(.WIDTH(kti_pkg::DUR_W), .DEPTH(kti_pkg::MAX_POINTS)) u_dur_ram (
        .clk   (clk),
        .we    (dur_we),
        .waddr (count_reg[kti_pkg::IDX_W-1:0]),
        .wdata (cmd_reg.segment_duration),
        .raddr (idx_reg),
        .rdata (dur_rdata)
    );

    kti_ram #(.WIDTH(kti_pkg::TIME_W), .DEPTH(kti_pkg::MAX_POINTS)) u_end_ram (
        .clk   (clk),
        .we    (end_we),
        .waddr (idx_reg),
        .wdata (run_sat),
        .raddr (idx_reg),
        .rdata (end_rdata)
    );

    kti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[kti_pkg::MAG_W-1:0]),
        .divisor  (d_reg),
        .quotient (div_quo),
        .status   (div_status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kti_pkg::ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            last_reg      <= '0;
            start_val_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                start_val_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        out_data_reg <= out_data_next;
        idx_reg      <= idx_next;
        run_reg      <= run_next;
        t_reg        <= t_next;
        prev_end_reg <= prev_end_next;
        acc_reg      <= acc_next;
        to_reg       <= to_next;
        from_reg     <= from_next;
        d_reg        <= d_next;
        elapsed_reg  <= elapsed_next;
        diff_reg     <= diff_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
    end

    always_comb
    begin
        count_m1     = count_reg - kti_pkg::CNT_W'(1);
        last_idx     = count_m1[kti_pkg::IDX_W-1:0];
        run_sum      = {1'b0, run_reg} + (kti_pkg::TIME_W + 1)'(dur_rdata);
        run_sat      = run_sum[kti_pkg::TIME_W] ? kti_pkg::TIME_MAX
                                                 : run_sum[kti_pkg::TIME_W-1:0];
        elapsed_full = (t_reg > prev_end_reg) ? (t_reg - prev_end_reg) : '0;
        from_sel     = (idx_reg == '0) ? start_val_reg : val_rdata;
        prod_abs     = prod_reg[kti_pkg::PROD_W-1] ? -prod_reg : prod_reg;
        q_signed     = neg_reg ? -{1'b0, div_quo} : {1'b0, div_quo};
        tween_sum    = {from_reg[kti_pkg::VALUE_W-1], from_reg} + q_signed;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        idx_next       = idx_reg;
        run_next       = run_reg;
        t_next         = t_reg;
        prev_end_next  = prev_end_reg;
        acc_next       = acc_reg;
        to_next        = to_reg;
        from_next      = from_reg;
        d_next         = d_reg;
        elapsed_next   = elapsed_reg;
        diff_next      = diff_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        in_ready       = 1'b0;
        val_we         = 1'b0;
        dur_we         = 1'b0;
        end_we         = 1'b0;
        val_raddr      = idx_reg;
        div_start      = 1'b0;

        // drop the output item once it transfers
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            kti_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next   = in_data;
                    state_next = kti_pkg::ST_DISPATCH;
                end
            end

            kti_pkg::ST_DISPATCH:
            begin
                acc_next   = 1'b1;
                t_next     = '0;
                idx_next   = '0;
                state_next = kti_pkg::ST_OUT;
                unique case (cmd_reg.opcode)
                    kti_pkg::OP_APPEND:
                    begin
                        if (count_reg >= kti_pkg::CNT_W'(kti_pkg::MAX_POINTS))
                        begin
                            acc_next = 1'b0;
                        end
                        else
                        begin
                            val_we     = 1'b1;
                            dur_we     = 1'b1;
                            count_next = count_reg + kti_pkg::CNT_W'(1);
                        end
                    end
                    kti_pkg::OP_START:
                    begin
                        run_next = '0;
                        if (count_reg == '0)
                        begin
                            total_next = '0;
                        end
                        else
                        begin
                            state_next = kti_pkg::ST_START_RD;
                        end
                    end
                    kti_pkg::OP_RENDER:
                    begin
                        if (count_reg == '0)
                        begin
                            last_next = start_val_reg;
                        end
                        else
                        begin
                            t_next        = (cmd_reg.query_time > total_reg) ? total_reg
                                                                             : cmd_reg.query_time;
                            prev_end_next = '0;
                            state_next    = kti_pkg::ST_SEARCH_RD;
                        end
                    end
                    default:
                    begin
                        state_next = kti_pkg::ST_OUT;
                    end
                endcase
            end

            kti_pkg::ST_START_RD:
            begin
                state_next = kti_pkg::ST_START_ACC;
            end

            kti_pkg::ST_START_ACC:
            begin
                end_we   = 1'b1;
                run_next = run_sat;
                if (idx_reg == last_idx)
                begin
                    total_next = run_sat;
                    state_next = kti_pkg::ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + kti_pkg::IDX_W'(1);
                    state_next = kti_pkg::ST_START_RD;
                end
            end

            kti_pkg::ST_SEARCH_RD:
            begin
                state_next = kti_pkg::ST_SEARCH_CHK;
            end

            kti_pkg::ST_SEARCH_CHK:
            begin
                // advance past points that end before t; stop at the last point regardless
                if ((t_reg > end_rdata) && (idx_reg != last_idx))
                begin
                    prev_end_next = end_rdata;
                    idx_next      = idx_reg + kti_pkg::IDX_W'(1);
                    state_next    = kti_pkg::ST_SEARCH_RD;
                end
                else
                begin
                    state_next = kti_pkg::ST_FETCH_TO;
                end
            end

            kti_pkg::ST_FETCH_TO:
            begin
                state_next = kti_pkg::ST_FETCH_FROM;
            end

            kti_pkg::ST_FETCH_FROM:
            begin
                to_next    = val_rdata;
                d_next     = dur_rdata;
                val_raddr  = idx_reg - kti_pkg::IDX_W'(1);
                state_next = kti_pkg::ST_DIFF;
            end

            kti_pkg::ST_DIFF:
            begin
                from_next = from_sel;
                diff_next = $signed({to_reg[kti_pkg::VALUE_W-1], to_reg})
                          - $signed({from_sel[kti_pkg::VALUE_W-1], from_sel});
                if (elapsed_full > kti_pkg::TIME_W'(d_reg))
                begin
                    elapsed_next = d_reg;
                end
                else
                begin
                    elapsed_next = elapsed_full[kti_pkg::DUR_W-1:0];
                end
                state_next = kti_pkg::ST_PROD;
            end

            kti_pkg::ST_PROD:
            begin
                if (d_reg == '0)
                begin
                    last_next  = to_reg;
                    state_next = kti_pkg::ST_OUT;
                end
                else
                begin
                    prod_next  = kti_pkg::PROD_W'(diff_reg)
                               * kti_pkg::PROD_W'($signed({1'b0, elapsed_reg}));
                    state_next = kti_pkg::ST_DIV_GO;
                end
            end

            kti_pkg::ST_DIV_GO:
            begin
                neg_next   = prod_reg[kti_pkg::PROD_W-1];
                div_start  = 1'b1;
                state_next = kti_pkg::ST_DIV_WAIT;
            end

            kti_pkg::ST_DIV_WAIT:
            begin
                if (div_status.done && !div_status.busy)
                begin
                    state_next = kti_pkg::ST_FINISH;
                end
            end

            kti_pkg::ST_FINISH:
            begin
                last_next  = tween_sum[kti_pkg::VALUE_W-1:0];
                state_next = kti_pkg::ST_OUT;
            end

            kti_pkg::ST_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.tween_value  = last_reg;
                    out_data_next.clamped_time = t_reg;
                    out_data_next.accepted     = acc_reg;
                    state_next                 = kti_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = kti_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
